// ===== hdl/cgfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cgfr_pkg: shared types and codes of the CAN gateway filter and rewriter
// Command and status codes, and the item types of the input and result channels.
// ----------------------------------------------------------------------------
package cgfr_pkg;

	typedef enum logic [2:0] {
		CMD_FRAME    = 3'd0,
		CMD_DROP_ADD = 3'd1,
		CMD_DROP_DEL = 3'd2,
		CMD_REP_LOAD = 3'd3,
		CMD_LOG_LOAD = 3'd4
	} cmd_t;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] frame_id;
		logic        from_second_bus;
		logic [63:0] payload;
		logic [31:0] skip_limit;
		logic [31:0] send_limit;
		logic [63:0] change_mask;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        forward_valid;
		logic        dest_second_bus;
		logic [31:0] out_id;
		logic [63:0] out_payload;
		logic        replaced;
		logic        log_valid;
	} out_item_t;

endpackage

// ===== hdl/cgfr_in_if.sv =====
// ----------------------------------------------------------------------------
// cgfr_in_if: input item channel
// Valid and ready handshake carrying one command or frame item.
// ----------------------------------------------------------------------------
interface cgfr_in_if;
	import cgfr_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cgfr_out_if.sv =====
// ----------------------------------------------------------------------------
// cgfr_out_if: result item channel
// Valid and ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface cgfr_out_if;
	import cgfr_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cgfr_front.sv =====
// ----------------------------------------------------------------------------
// cgfr_front: input stage and item queue
// Takes input items into a short queue from which the table engine pulls them.
// ----------------------------------------------------------------------------
module cgfr_front (
	input  logic               clk,
	input  logic               arst_n,
	cgfr_in_if.sink            in_ch,
	output cgfr_pkg::in_item_t q_data,
	output logic               q_valid,
	input  logic               q_pop
);
	import cgfr_pkg::*;

	in_item_t   mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

// ===== hdl/cgfr_back.sv =====
// ----------------------------------------------------------------------------
// cgfr_back: table engine
// Scans the drop, replace and log tables one entry a cycle, then updates them
// and hands the result item to the output register.
// ----------------------------------------------------------------------------
module cgfr_back #(
	parameter int DROP_ENTRIES    = 16,
	parameter int REPLACE_ENTRIES = 16,
	parameter int LOG_ENTRIES     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cgfr_pkg::in_item_t q_data,
	input  logic               q_valid,
	output logic               q_pop,
	cgfr_out_if.source         out_ch
);
	import cgfr_pkg::*;

	localparam int MAXN = (DROP_ENTRIES > REPLACE_ENTRIES) ?
		((DROP_ENTRIES > LOG_ENTRIES) ? DROP_ENTRIES : LOG_ENTRIES) :
		((REPLACE_ENTRIES > LOG_ENTRIES) ? REPLACE_ENTRIES : LOG_ENTRIES);
	localparam int CW = $clog2(MAXN + 1);
	localparam int DW = (DROP_ENTRIES > 1) ? $clog2(DROP_ENTRIES) : 1;
	localparam int RW = (REPLACE_ENTRIES > 1) ? $clog2(REPLACE_ENTRIES) : 1;
	localparam int LW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_OUT} state_t;

	typedef struct packed {
		logic          hit;
		logic [CW-1:0] idx;
		logic          free_ok;
		logic [CW-1:0] free_idx;
	} look_t;

	// Tables, each entry read at the scan index or, after the scan, at the matched index.
	logic [31:0] drop_key_q  [DROP_ENTRIES];
	logic [DROP_ENTRIES-1:0] drop_used_q;
	logic [31:0] rep_key_q   [REPLACE_ENTRIES];
	logic [REPLACE_ENTRIES-1:0] rep_used_q;
	logic [31:0] rep_skip_q  [REPLACE_ENTRIES];
	logic [31:0] rep_send_q  [REPLACE_ENTRIES];
	logic [31:0] rep_seen_q  [REPLACE_ENTRIES];
	logic [31:0] rep_sent_q  [REPLACE_ENTRIES];
	logic [63:0] rep_data_q  [REPLACE_ENTRIES];
	logic [31:0] log_key_q   [LOG_ENTRIES];
	logic [LOG_ENTRIES-1:0] log_used_q;
	logic [63:0] log_mask_q  [LOG_ENTRIES];
	logic [63:0] log_last_q  [LOG_ENTRIES];

	state_t        state_q;
	in_item_t      item_q;
	logic [CW-1:0] scan_q;
	look_t         dlk_q, rlk_q, llk_q;
	out_item_t     res_q;
	logic          oval_q;

	logic [DW-1:0] di, dx, df;
	logic [RW-1:0] ri, rx, rf;
	logic [LW-1:0] li, lx, lf;
	logic [31:0]   seen_n;
	logic          do_rep, log_chg;
	logic [63:0]   data_n;
	out_item_t     res_n;
	logic          exec_go;

	assign di = scan_q[DW-1:0];
	assign ri = scan_q[RW-1:0];
	assign li = scan_q[LW-1:0];
	assign dx = dlk_q.idx[DW-1:0];
	assign df = dlk_q.free_idx[DW-1:0];
	assign rx = rlk_q.idx[RW-1:0];
	assign rf = rlk_q.free_idx[RW-1:0];
	assign lx = llk_q.idx[LW-1:0];
	assign lf = llk_q.free_idx[LW-1:0];

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_ch.valid = oval_q;
	assign out_ch.data = res_q;

	// The tables and the result register change only once the previous result has left.
	assign exec_go = (state_q == S_EXEC) && (!oval_q || out_ch.ready);

	// Frame decision for the matched replace entry, and the change check for the matched log entry.
	always_comb begin
		seen_n = (rep_seen_q[rx] != 32'hFFFF_FFFF) ? rep_seen_q[rx] + 32'd1 : rep_seen_q[rx];
		do_rep = rlk_q.hit && (seen_n > rep_skip_q[rx]) &&
			((rep_send_q[rx] == 32'd0) || (rep_sent_q[rx] < rep_send_q[rx]));
		data_n = do_rep ? rep_data_q[rx] : item_q.payload;
		log_chg = llk_q.hit && (((log_last_q[lx] ^ data_n) & log_mask_q[lx]) != 64'd0);
	end

	always_comb begin
		res_n = '0;
		case (item_q.command)
			CMD_FRAME: begin
				res_n.forward_valid = !dlk_q.hit;
				res_n.dest_second_bus = ~item_q.from_second_bus;
				res_n.out_id = item_q.frame_id;
				res_n.out_payload = data_n;
				res_n.replaced = do_rep;
				res_n.log_valid = log_chg;
			end
			CMD_DROP_ADD: begin
				if (dlk_q.hit) res_n.status = ST_PRESENT;
				else if (!dlk_q.free_ok) res_n.status = ST_FULL;
			end
			CMD_DROP_DEL: begin
				if (!dlk_q.hit) res_n.status = ST_ABSENT;
			end
			CMD_REP_LOAD: begin
				if (rlk_q.hit) res_n.status = ST_PRESENT;
				else if (!rlk_q.free_ok) res_n.status = ST_FULL;
			end
			CMD_LOG_LOAD: begin
				if (llk_q.hit) res_n.status = ST_PRESENT;
				else if (!llk_q.free_ok) res_n.status = ST_FULL;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			case (item_q.command)
				CMD_FRAME: begin
					if (rlk_q.hit) begin
						rep_seen_q[rx] <= seen_n;
						if (do_rep && rep_send_q[rx] != 32'd0)
							rep_sent_q[rx] <= rep_sent_q[rx] + 32'd1;
					end
					if (log_chg) log_last_q[lx] <= data_n;
				end
				CMD_DROP_ADD: begin
					if (!dlk_q.hit && dlk_q.free_ok) drop_key_q[df] <= item_q.frame_id;
				end
				CMD_REP_LOAD: begin
					if (!rlk_q.hit && rlk_q.free_ok) begin
						rep_key_q[rf]  <= item_q.frame_id;
						rep_skip_q[rf] <= item_q.skip_limit;
						rep_send_q[rf] <= item_q.send_limit;
						rep_seen_q[rf] <= 32'd0;
						rep_sent_q[rf] <= 32'd0;
						rep_data_q[rf] <= item_q.payload;
					end
				end
				CMD_LOG_LOAD: begin
					if (!llk_q.hit && llk_q.free_ok) begin
						log_key_q[lf]  <= item_q.frame_id;
						log_mask_q[lf] <= item_q.change_mask;
						log_last_q[lf] <= 64'd0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			oval_q <= 1'b0;
			drop_used_q <= '0;
			rep_used_q <= '0;
			log_used_q <= '0;
			scan_q <= '0;
			dlk_q <= '0;
			rlk_q <= '0;
			llk_q <= '0;
			item_q <= '0;
			res_q <= '0;
		end else begin
			if (state_q == S_OUT) oval_q <= 1'b1;
			else if (oval_q && out_ch.ready) oval_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						item_q <= q_data;
						scan_q <= '0;
						dlk_q <= '0;
						rlk_q <= '0;
						llk_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_q < CW'(DROP_ENTRIES)) begin
						if (!dlk_q.hit && drop_used_q[di] && drop_key_q[di] == item_q.frame_id) begin
							dlk_q.hit <= 1'b1;
							dlk_q.idx <= scan_q;
						end
						if (!dlk_q.free_ok && !drop_used_q[di]) begin
							dlk_q.free_ok <= 1'b1;
							dlk_q.free_idx <= scan_q;
						end
					end
					if (scan_q < CW'(REPLACE_ENTRIES)) begin
						if (!rlk_q.hit && rep_used_q[ri] && rep_key_q[ri] == item_q.frame_id) begin
							rlk_q.hit <= 1'b1;
							rlk_q.idx <= scan_q;
						end
						if (!rlk_q.free_ok && !rep_used_q[ri]) begin
							rlk_q.free_ok <= 1'b1;
							rlk_q.free_idx <= scan_q;
						end
					end
					if (scan_q < CW'(LOG_ENTRIES)) begin
						if (!llk_q.hit && log_used_q[li] && log_key_q[li] == item_q.frame_id) begin
							llk_q.hit <= 1'b1;
							llk_q.idx <= scan_q;
						end
						if (!llk_q.free_ok && !log_used_q[li]) begin
							llk_q.free_ok <= 1'b1;
							llk_q.free_idx <= scan_q;
						end
					end
					if (scan_q == CW'(MAXN - 1)) state_q <= S_EXEC;
					else scan_q <= scan_q + 1'b1;
				end
				S_EXEC: begin
					if (exec_go) begin
						res_q <= res_n;
						case (item_q.command)
							CMD_DROP_ADD: begin
								if (!dlk_q.hit && dlk_q.free_ok) drop_used_q[df] <= 1'b1;
							end
							CMD_DROP_DEL: begin
								if (dlk_q.hit) drop_used_q[dx] <= 1'b0;
							end
							CMD_REP_LOAD: begin
								if (!rlk_q.hit && rlk_q.free_ok) rep_used_q[rf] <= 1'b1;
							end
							CMD_LOG_LOAD: begin
								if (!llk_q.hit && llk_q.free_ok) log_used_q[lf] <= 1'b1;
							end
							default: begin
							end
						endcase
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/can_gateway_filter_rewriter_unit.sv =====
// An item passes from acceptance through the queue and the IDLE, SCAN, EXEC and OUT
// states to the result; SCAN walks max(DROP_ENTRIES, REPLACE_ENTRIES, LOG_ENTRIES) entries.
// The engine works on one item at a time, paced by the shared entry-by-entry
// table scan. A two-item queue takes items while the engine works.
// Reset clears the used flags of all three tables at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// can_gateway_filter_rewriter_unit: CAN gateway filter and rewriter
// Drops, rewrites and logs frames between two buses and edits its tables.
// ----------------------------------------------------------------------------
module can_gateway_filter_rewriter_unit #(
	parameter int DROP_ENTRIES    = 16,
	parameter int REPLACE_ENTRIES = 16,
	parameter int LOG_ENTRIES     = 16
) (
	input logic        clk,
	input logic        arst_n,
	cgfr_in_if.sink    in_ch,
	cgfr_out_if.source out_ch
);
	import cgfr_pkg::*;

	in_item_t q_data;
	logic     q_valid, q_pop;

	cgfr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
	);

	cgfr_back #(
		.DROP_ENTRIES(DROP_ENTRIES), .REPLACE_ENTRIES(REPLACE_ENTRIES),
		.LOG_ENTRIES(LOG_ENTRIES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_data(q_data), .q_valid(q_valid),
		.q_pop(q_pop), .out_ch(out_ch)
	);

	// A pop only happens when the queue holds an item.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue popped while empty");
	// A command result with a status other than done never forwards or logs.
	a_cmd_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.status != ST_DONE) |->
		(!out_ch.data.forward_valid && !out_ch.data.log_valid))
		else $error("command result carries frame fields");
	// A replaced payload belongs to a frame result.
	a_rep_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.replaced) |-> out_ch.data.status == ST_DONE)
		else $error("replacement flagged on a failed command");
endmodule
